[rtl/als_pkg.sv]
`timescale 1ns / 1ps

package als_pkg;

  // Element width, fixed by the stream format
  localparam int DATA_W = 32;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_LOAD     = 5'b00001,
    ST_SCAN_RD  = 5'b00010,
    ST_SCAN_CMP = 5'b00100,
    ST_EMIT_RD  = 5'b01000,
    ST_EMIT_CHK = 5'b10000
  } state_t;

  // Result of one pass through the compare unit
  typedef struct packed {
    logic                     take;
    logic signed [DATA_W-1:0] max;
  } cmp_res_t;

endpackage

[rtl/array_leader_select_top.sv]
`timescale 1ns / 1ps

// Channel  Dir  Handshake            Payload
// s        in   s_tvalid/s_tready    s_tdata = value, s_tlast = is_final
// m        out  m_tvalid/m_tready    m_tdata = leader, m_tlast = last_of_run,
//                                    m_tuser = overflow
//
// A non-final beat is stored, or sets the overflow flag once the store is full. A final beat
// starts a backward scan (registered RAM read, then the shared compare unit, per stored
// element), then a forward walk (registered RAM read, then mark check, per element). s_tready
// is low during scan and walk. A stalled result holds in the output register; the walk waits
// on it only when the next leader is ready. Synchronous reset clears count, overflow flag,
// state, indices and m_tvalid; the RAMs need no reset.

module array_leader_select_top
  import als_pkg::*;
#(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] leader
  output logic        m_tlast,
  output logic        m_tuser    // [0] overflow
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  state_t                   state;
  logic [CW-1:0]            count;
  logic                     ovf_seen;
  logic [AW-1:0]            idx;
  logic [AW-1:0]            last_idx;
  logic signed [DATA_W-1:0] run_max;

  logic                     s_beat;
  logic                     store_en;
  logic [DATA_W-1:0]        elem_rdata;
  logic                     mark_rdata;
  logic                     mark_we;
  cmp_res_t                 cmp_res;
  logic                     out_busy;
  logic                     out_load;
  logic                     emit_adv;

  assign s_tready = (state == ST_LOAD);
  assign s_beat   = s_tvalid && s_tready;
  assign store_en = s_beat && (count < CW'(MAX_ELEMENTS));

  // Element store
  als_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_ELEMENTS)
  ) u_elem_ram (
    .clk  (clk),
    .we   (store_en),
    .waddr(count[AW-1:0]),
    .wdata(s_tdata),
    .raddr(idx),
    .rdata(elem_rdata)
  );

  // Leader marks, written during the backward scan
  assign mark_we = (state == ST_SCAN_CMP);

  als_ram #(
    .WIDTH(1),
    .DEPTH(MAX_ELEMENTS)
  ) u_mark_ram (
    .clk  (clk),
    .we   (mark_we),
    .waddr(idx),
    .wdata(cmp_res.take),
    .raddr(idx),
    .rdata(mark_rdata)
  );

  // Shared compare unit
  als_cmp u_cmp (
    .elem   (elem_rdata),
    .cur_max(run_max),
    .first  (idx == last_idx),
    .res    (cmp_res)
  );

  // Output register handshake
  assign out_busy = m_tvalid && !m_tready;
  assign out_load = (state == ST_EMIT_CHK) && mark_rdata && !out_busy;
  assign emit_adv = (state == ST_EMIT_CHK) && (!mark_rdata || !out_busy);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= elem_rdata;
      m_tlast <= (idx == last_idx);
      m_tuser <= ovf_seen;
    end
  end

  // Running maximum of the backward scan
  always_ff @(posedge clk) begin
    if (state == ST_SCAN_CMP) begin
      run_max <= cmp_res.max;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      ovf_seen <= 1'b0;
      idx      <= '0;
      last_idx <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (s_beat) begin
            if (store_en) begin
              count <= count + CW'(1);
            end else begin
              ovf_seen <= 1'b1;
            end
            if (s_tlast) begin
              if (store_en) begin
                last_idx <= count[AW-1:0];
                idx      <= count[AW-1:0];
              end else begin
                last_idx <= AW'(MAX_ELEMENTS - 1);
                idx      <= AW'(MAX_ELEMENTS - 1);
              end
              state <= ST_SCAN_RD;
            end
          end
        end
        ST_SCAN_RD: begin
          state <= ST_SCAN_CMP;
        end
        ST_SCAN_CMP: begin
          if (idx == '0) begin
            state <= ST_EMIT_RD;
          end else begin
            idx   <= idx - AW'(1);
            state <= ST_SCAN_RD;
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_CHK;
        end
        ST_EMIT_CHK: begin
          if (emit_adv) begin
            if (idx == last_idx) begin
              count    <= '0;
              ovf_seen <= 1'b0;
              state    <= ST_LOAD;
            end else begin
              idx   <= idx + AW'(1);
              state <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Count never runs past the store depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ELEMENTS))
    else $error("element count beyond store depth");

  // Overflow only once the store is full
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf_seen |-> (count == CW'(MAX_ELEMENTS)))
    else $error("overflow flag with store not full");

  // The final leader ends the walk and clears the run state
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_load && (idx == last_idx)) |=> (state == ST_LOAD) && (count == '0) && !ovf_seen)
    else $error("walk did not end on the final leader");

  // A loaded result is shown on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid)
    else $error("loaded result not presented");
`endif

endmodule

[rtl/als_ram.sv]
`timescale 1ns / 1ps

module als_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/als_cmp.sv]
`timescale 1ns / 1ps

module als_cmp
  import als_pkg::*;
(
  input  logic signed [DATA_W-1:0] elem,
  input  logic signed [DATA_W-1:0] cur_max,
  input  logic                     first,
  output cmp_res_t                 res
);

  // Take the element when it is the first one scanned or not strictly below the running maximum
  always_comb begin
    res.take = first || (elem >= cur_max);
    res.max  = res.take ? elem : cur_max;
  end

endmodule
